### design/wrs_pkg.sv
package wrs_pkg;

	localparam int ACTION_W = 2;
	localparam int WEIGHT_W = 16;
	localparam int TOTAL_W  = 24;
	localparam int INDEX_W  = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// request actions; code 3 is unused and leaves the state alone
	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STS_ABOVE = 2'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [WEIGHT_W-1:0] weight;
		logic [TOTAL_W-1:0]  draw;
	} req_t;

	typedef struct packed {
		logic [INDEX_W-1:0]  index;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [TOTAL_W-1:0]  total;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;       // capture the accepted request
		logic decide;      // settle the result of one-step actions
		logic scan_start;  // rewind the scan address and running sum
		logic scan_step;   // issue one table read, fold in the previous one
		logic emit;        // load the output register and commit the state
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_select;
		logic empty;
		logic above;
		logic hit;
		logic out_free;
	} dp_sts_t;

endpackage

### design/wrs_ctrl.sv
module wrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  wrs_pkg::dp_sts_t   sts,
	output wrs_pkg::ctl_cmd_t  cmd
);

	wrs_pkg::state_t state_q;
	wrs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			wrs_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = wrs_pkg::S_DECIDE;
				end
			end
			wrs_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.is_select && !sts.empty && !sts.above) begin
					cmd.scan_start = 1'b1;
					state_d        = wrs_pkg::S_SCAN;
				end else begin
					state_d = wrs_pkg::S_EMIT;
				end
			end
			wrs_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.hit) begin
					state_d = wrs_pkg::S_EMIT;
				end
			end
			wrs_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = wrs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = wrs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### design/wrs_dpath.sv
module wrs_dpath #(
	parameter int MAX_ENTRIES = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wrs_pkg::req_t      req_data,
	input  wrs_pkg::ctl_cmd_t  cmd,
	output wrs_pkg::dp_sts_t   sts,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output wrs_pkg::rsp_t      rsp_data
);

	localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int SUM_W = ((WEIGHT_BITS > wrs_pkg::TOTAL_W) ? WEIGHT_BITS
	                       : wrs_pkg::TOTAL_W) + 1;
	// running sum stays below draw before each add, so one extra bit is enough
	localparam int CUM_W = SUM_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

	// captured request
	wrs_pkg::req_t req_q;

	// architectural state
	logic [CNT_W-1:0]               count_q;
	logic [wrs_pkg::TOTAL_W-1:0]    total_q;
	logic [WEIGHT_BITS-1:0]         weight_mem [MAX_ENTRIES];

	// scan
	logic [AW-1:0]          rd_addr_q;
	logic [WEIGHT_BITS-1:0] rd_data_s1;
	logic                   rd_vld_s1;
	logic [AW-1:0]          proc_idx_s1;
	logic [CUM_W-1:0]       cum_q;

	// result
	logic [AW-1:0]                 res_idx_q;
	logic [wrs_pkg::STATUS_W-1:0]  res_status_q;
	logic                          out_valid_q;
	wrs_pkg::rsp_t                 out_q;

	logic [WEIGHT_BITS-1:0]       w_in;
	logic [CNT_W-1:0]             cnt_m1;
	logic                         full;
	logic                         is_add;
	logic                         is_clear;
	logic                         do_add;
	logic [SUM_W-1:0]             total_sum;
	logic [wrs_pkg::TOTAL_W-1:0]  total_sat;
	logic [CNT_W-1:0]             count_next;
	logic [wrs_pkg::TOTAL_W-1:0]  total_next;
	logic [CUM_W-1:0]             cum_sum;
	logic                         scan_ge;
	logic                         scan_last;

	assign w_in     = WEIGHT_BITS'(req_q.weight);
	assign cnt_m1   = count_q - 1'b1;
	assign full     = (count_q >= CNT_FULL);
	assign is_add   = (req_q.action == wrs_pkg::ACT_ADD);
	assign is_clear = (req_q.action == wrs_pkg::ACT_CLEAR);
	assign do_add   = is_add && !full;

	assign total_sum = SUM_W'(total_q) + SUM_W'(w_in);
	assign total_sat = (total_sum > SUM_W'(wrs_pkg::TOTAL_MAX)) ? wrs_pkg::TOTAL_MAX
	                   : total_sum[wrs_pkg::TOTAL_W-1:0];

	always_comb begin
		count_next = count_q;
		total_next = total_q;
		if (do_add) begin
			count_next = count_q + 1'b1;
			total_next = total_sat;
		end else if (is_clear) begin
			count_next = '0;
			total_next = '0;
		end
	end

	assign cum_sum   = cum_q + CUM_W'(rd_data_s1);
	assign scan_ge   = (cum_sum >= CUM_W'(req_q.draw));
	assign scan_last = (proc_idx_s1 == cnt_m1[AW-1:0]);

	assign sts.is_select = (req_q.action == wrs_pkg::ACT_SELECT);
	assign sts.empty     = (count_q == '0);
	assign sts.above     = (req_q.draw > total_q);
	assign sts.hit       = rd_vld_s1 && (scan_ge || scan_last);
	assign sts.out_free  = !out_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_data;
		end
	end

	// weight table: one write port at commit, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (cmd.emit && do_add) begin
			weight_mem[count_q[AW-1:0]] <= w_in;
		end
		if (cmd.scan_step) begin
			rd_data_s1 <= weight_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			proc_idx_s1 <= rd_addr_q;
		end
		if (cmd.scan_start) begin
			rd_addr_q <= '0;
			cum_q     <= '0;
		end else if (cmd.scan_step) begin
			rd_addr_q <= rd_addr_q + 1'b1;
			if (rd_vld_s1) begin
				cum_q <= cum_sum;
			end
		end
		if (cmd.decide) begin
			unique case (req_q.action)
				wrs_pkg::ACT_ADD: begin
					if (full) begin
						res_idx_q    <= '0;
						res_status_q <= wrs_pkg::STS_FULL;
					end else begin
						res_idx_q    <= count_q[AW-1:0];
						res_status_q <= wrs_pkg::STS_OK;
					end
				end
				wrs_pkg::ACT_SELECT: begin
					if (count_q == '0) begin
						res_idx_q    <= '0;
						res_status_q <= wrs_pkg::STS_EMPTY;
					end else if (req_q.draw > total_q) begin
						res_idx_q    <= cnt_m1[AW-1:0];
						res_status_q <= wrs_pkg::STS_ABOVE;
					end else begin
						res_idx_q    <= '0;
						res_status_q <= wrs_pkg::STS_OK;
					end
				end
				default: begin
					res_idx_q    <= '0;
					res_status_q <= wrs_pkg::STS_OK;
				end
			endcase
		end else if (cmd.scan_step && sts.hit) begin
			res_idx_q    <= proc_idx_s1;
			res_status_q <= wrs_pkg::STS_OK;
		end
		if (cmd.emit) begin
			out_q.index  <= wrs_pkg::INDEX_W'(res_idx_q);
			out_q.status <= res_status_q;
			out_q.count  <= wrs_pkg::COUNT_W'(count_next);
			out_q.total  <= total_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.emit) begin
				count_q     <= count_next;
				total_q     <= total_next;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("entry count beyond table depth");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || rsp_ready))
		else $error("result loaded over an untaken result");

	a_hit_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && sts.hit) |-> (CNT_W'(proc_idx_s1) < count_q))
		else $error("scan stopped past the last entry");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && do_add) |=> (total_q >= $past(total_q)))
		else $error("total fell on add");

endmodule

### design/weighted_roulette_selector.sv
// Channel   Ports                             Direction  Moves
// request   req_valid req_ready req_data      in         one action: add / select / clear
// result    rsp_valid rsp_ready rsp_data      out        index, status, count, total
//
// One request is in work at a time; a new one is taken only in idle.
// Add, clear and unused codes go from accept through decide to result load, no scan.
// A select that stops at entry j scans from entry 0 up to j, one table read per
// cycle through the registered read port, before the result load.
// Empty table or draw above total: no scan, straight from decide to result load.
// A result waits in the output register; the next request is taken meanwhile,
// but its result is held in the emit state until the register frees up.
// Reset clears count, total and control; the weight table is not cleared.
module weighted_roulette_selector #(
	parameter int MAX_ENTRIES = 256,
	parameter int WEIGHT_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  wrs_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output wrs_pkg::rsp_t  rsp_data
);

	// command / status between sequencer and datapath
	wrs_pkg::ctl_cmd_t cmd;
	wrs_pkg::dp_sts_t  sts;

	// sequencer: idle -> decide -> (scan) -> emit
	wrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// weight table, running sums, scan pipeline, output register
	wrs_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

// Roulette-wheel selector bench.
// A directed table opens the run: empty-table selects, the unused action code,
// zero weights, draws of zero, draws exactly at and just above the total, and
// clears. The random part follows as episodes: clear, build a table of some
// size (a few of them past full), and select at random draws in between.
// Results are checked against a shadow copy of the weight table or a hand-written row.
module testbench;

	localparam int MAX_ENTRIES  = 256;
	localparam int WEIGHT_BITS  = 16;
	localparam int RANDOM_ITEMS = 1350;
	localparam int HOLD_AFTER   = 400;     // results taken before the long stall
	localparam int HOLD_CYCLES  = 700;     // well past two full-table scans
	localparam int CYCLE_LIMIT  = 1500000;

	// action 3 has no function; the block must just echo its state
	localparam logic [wrs_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [wrs_pkg::WEIGHT_W-1:0] WEIGHT_MASK =
		{wrs_pkg::WEIGHT_W{1'b1}} >> (wrs_pkg::WEIGHT_W - WEIGHT_BITS);

	typedef struct packed {
		wrs_pkg::req_t req;
		logic          typed;   // want holds a hand-written result
		wrs_pkg::rsp_t want;
	} step_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	wrs_pkg::req_t req_data;
	logic          rsp_valid;
	logic          rsp_ready;
	wrs_pkg::rsp_t rsp_data;

	// shadow of the block's state
	logic [wrs_pkg::WEIGHT_W-1:0] shadow_weights [MAX_ENTRIES];
	int                           shadow_count;
	logic [wrs_pkg::TOTAL_W-1:0]  shadow_total;

	wrs_pkg::rsp_t pending_outcomes [$];
	step_t         plan [$];
	int            requests_sent;
	int            results_taken;
	int            mismatches;
	int            cycle_count;
	bit            feed_burst;    // sender runs back to back while set
	bit            drain_burst;   // receiver skips random stalls while set

	weighted_roulette_selector #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	always #5 clk = ~clk;

	// hard stop in case the block hangs or a result goes missing
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result of one request, advancing the shadow state as the block would.
	function automatic wrs_pkg::rsp_t roulette_outcome(input wrs_pkg::req_t r);
		wrs_pkg::rsp_t                o;
		logic [wrs_pkg::WEIGHT_W-1:0] w;
		logic [wrs_pkg::TOTAL_W:0]    sum;
		logic [31:0]                  cum;
		bit                           found;
		o = '0;
		w = r.weight & WEIGHT_MASK;
		case (r.action)
			wrs_pkg::ACT_ADD: begin
				if (shadow_count >= MAX_ENTRIES) begin
					// full: weight dropped, nothing changes
					o.status = wrs_pkg::STS_FULL;
				end else begin
					shadow_weights[shadow_count] = w;
					o.index = shadow_count[wrs_pkg::INDEX_W-1:0];
					shadow_count++;
					sum = shadow_total + w;
					shadow_total = (sum > wrs_pkg::TOTAL_MAX) ? wrs_pkg::TOTAL_MAX
						: sum[wrs_pkg::TOTAL_W-1:0];
					o.status = wrs_pkg::STS_OK;
				end
			end
			wrs_pkg::ACT_SELECT: begin
				if (shadow_count == 0) begin
					o.status = wrs_pkg::STS_EMPTY;
				end else if (r.draw > shadow_total) begin
					o.index  = wrs_pkg::INDEX_W'(shadow_count - 1);
					o.status = wrs_pkg::STS_ABOVE;
				end else begin
					// first entry whose running sum reaches the draw
					cum   = '0;
					found = 1'b0;
					o.index  = wrs_pkg::INDEX_W'(shadow_count - 1);
					o.status = wrs_pkg::STS_OK;
					for (int i = 0; i < shadow_count && !found; i++) begin
						cum += shadow_weights[i];
						if (cum >= r.draw) begin
							o.index = wrs_pkg::INDEX_W'(i);
							found   = 1'b1;
						end
					end
				end
			end
			wrs_pkg::ACT_CLEAR: begin
				shadow_count = 0;
				shadow_total = '0;
			end
			default: ;
		endcase
		o.count = shadow_count[wrs_pkg::COUNT_W-1:0];
		o.total = shadow_total;
		return o;
	endfunction

	// Random request; the fields an action ignores carry random noise.
	function automatic wrs_pkg::req_t random_request(
			input logic [wrs_pkg::ACTION_W-1:0] act);
		wrs_pkg::req_t r;
		int            roll;
		r.action = act;
		r.weight = wrs_pkg::WEIGHT_W'($urandom);
		r.draw   = wrs_pkg::TOTAL_W'($urandom);
		if (act == wrs_pkg::ACT_ADD) begin
			// lots of small and zero weights so selects walk deep into the table
			roll = $urandom_range(0, 7);
			if (roll == 0)
				r.weight = '0;
			else if (roll == 1)
				r.weight = '1;
			else if (roll < 4)
				r.weight = wrs_pkg::WEIGHT_W'($urandom_range(1, 255));
		end else if (act == wrs_pkg::ACT_SELECT) begin
			roll = $urandom_range(0, 19);
			if (roll < 13)
				r.draw = wrs_pkg::TOTAL_W'($urandom_range(0, shadow_total));
			else if (roll < 15)
				r.draw = shadow_total;
			else if (roll < 16)
				r.draw = '0;
			else if (roll < 18 && shadow_total != wrs_pkg::TOTAL_MAX)
				r.draw = wrs_pkg::TOTAL_W'($urandom_range(shadow_total + 1,
					wrs_pkg::TOTAL_MAX));
		end
		return r;
	endfunction

	function automatic void plan_row(input logic [wrs_pkg::ACTION_W-1:0] act,
			input logic [wrs_pkg::WEIGHT_W-1:0] w, input logic [wrs_pkg::TOTAL_W-1:0] d,
			input logic typed, input logic [wrs_pkg::INDEX_W-1:0] idx,
			input logic [wrs_pkg::STATUS_W-1:0] sts, input logic [wrs_pkg::COUNT_W-1:0] cnt,
			input logic [wrs_pkg::TOTAL_W-1:0] tot);
		step_t s;
		s.req.action = act;
		s.req.weight = w;
		s.req.draw   = d;
		s.typed      = typed;
		s.want.index  = idx;
		s.want.status = sts;
		s.want.count  = cnt;
		s.want.total  = tot;
		plan.insert(plan.size(), s);
	endfunction

	// Offer one request after a random gap and hold it until it is taken.
	// The outcome is queued once the handshake completes.
	task automatic send_request(input wrs_pkg::req_t r, input logic typed,
			input wrs_pkg::rsp_t typed_rsp);
		wrs_pkg::rsp_t outcome;
		int            gap;
		outcome = roulette_outcome(r);
		if (typed)
			outcome = typed_rsp;
		if ($urandom_range(0, 63) == 0)
			feed_burst = !feed_burst;
		gap = feed_burst ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		pending_outcomes.insert(pending_outcomes.size(), outcome);
		requests_sent++;
	endtask

	// Episodes: clear, grow the table toward a target size with selects mixed
	// in, then a few more selects. Now and then the target runs past full so
	// the dropped-weight case comes up; small tables are the common case.
	task automatic run_random();
		int   start;
		int   episode;
		int   adds_left;
		int   roll;
		int   tail;
		bit   to_full;
		start   = requests_sent;
		episode = 0;
		while (requests_sent - start < RANDOM_ITEMS) begin
			to_full = (episode == 1) || (episode == 5) || ($urandom_range(0, 39) == 0);
			if (to_full)
				adds_left = MAX_ENTRIES + $urandom_range(1, 4);
			else if ($urandom_range(0, 4) == 0)
				adds_left = $urandom_range(17, 64);
			else
				adds_left = $urandom_range(1, 16);
			send_request(random_request(wrs_pkg::ACT_CLEAR), 1'b0, '0);
			while (adds_left > 0 && requests_sent - start < RANDOM_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 58) begin
					send_request(random_request(wrs_pkg::ACT_ADD), 1'b0, '0);
					adds_left--;
				end else if (roll < 92) begin
					send_request(random_request(wrs_pkg::ACT_SELECT), 1'b0, '0);
				end else if (roll < 96) begin
					send_request(random_request(ACT_UNUSED), 1'b0, '0);
				end else if (!to_full && roll < 98) begin
					// clear in mid-build: the episode restarts from an empty table
					send_request(random_request(wrs_pkg::ACT_CLEAR), 1'b0, '0);
				end else begin
					send_request(random_request(wrs_pkg::ACT_ADD), 1'b0, '0);
				end
			end
			tail = $urandom_range(2, 12);
			while (tail > 0 && requests_sent - start < RANDOM_ITEMS) begin
				send_request(random_request(wrs_pkg::ACT_SELECT), 1'b0, '0);
				tail--;
			end
			episode++;
		end
	endtask

	// Request side and the run as a whole.
	initial begin : request_side
		arst_n        <= 1'b0;
		req_valid     <= 1'b0;
		req_data      <= '0;
		shadow_count  = 0;
		shadow_total  = '0;
		requests_sent = 0;
		mismatches    = 0;
		cycle_count   = 0;
		feed_burst    = 1'b0;

		// Hand-written results where they follow straight from the table
		// state; the remaining rows are left to the shadow model.
		//       action               weight    draw        typed idx   status
		//       count  total
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h000000, 1'b1, 8'd0, wrs_pkg::STS_EMPTY,
			9'd0, 24'h000000);
		plan_row(wrs_pkg::ACT_SELECT, 16'hFFFF, 24'hFFFFFF, 1'b1, 8'd0, wrs_pkg::STS_EMPTY,
			9'd0, 24'h000000);
		plan_row(ACT_UNUSED,          16'h1234, 24'hABCDEF, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd0, 24'h000000);
		plan_row(wrs_pkg::ACT_CLEAR,  16'h0000, 24'h000000, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd0, 24'h000000);
		plan_row(wrs_pkg::ACT_ADD,    16'h0000, 24'hFFFFFF, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd1, 24'h000000);
		// zero draw on a zero-weight entry still returns entry 0
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h000000, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd1, 24'h000000);
		plan_row(wrs_pkg::ACT_SELECT, 16'hFFFF, 24'h000001, 1'b1, 8'd0, wrs_pkg::STS_ABOVE,
			9'd1, 24'h000000);
		plan_row(wrs_pkg::ACT_ADD,    16'hFFFF, 24'h000000, 1'b1, 8'd1, wrs_pkg::STS_OK,
			9'd2, 24'h00FFFF);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h000001, 1'b0, '0,   '0,
			'0,   '0);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h00FFFF, 1'b1, 8'd1, wrs_pkg::STS_OK,
			9'd2, 24'h00FFFF);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h010000, 1'b1, 8'd1, wrs_pkg::STS_ABOVE,
			9'd2, 24'h00FFFF);
		plan_row(wrs_pkg::ACT_ADD,    16'h0100, 24'h000000, 1'b1, 8'd2, wrs_pkg::STS_OK,
			9'd3, 24'h0100FF);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h010000, 1'b0, '0,   '0,
			'0,   '0);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h0100FF, 1'b0, '0,   '0,
			'0,   '0);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'hFFFFFF, 1'b1, 8'd2, wrs_pkg::STS_ABOVE,
			9'd3, 24'h0100FF);
		plan_row(wrs_pkg::ACT_ADD,    16'h0001, 24'h000000, 1'b1, 8'd3, wrs_pkg::STS_OK,
			9'd4, 24'h010100);
		plan_row(wrs_pkg::ACT_SELECT, 16'hFFFF, 24'h000000, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd4, 24'h010100);
		plan_row(ACT_UNUSED,          16'hFFFF, 24'hFFFFFF, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd4, 24'h010100);
		plan_row(wrs_pkg::ACT_ADD,    16'h8000, 24'h000000, 1'b0, '0,   '0,
			'0,   '0);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h010100, 1'b0, '0,   '0,
			'0,   '0);
		plan_row(wrs_pkg::ACT_CLEAR,  16'hFFFF, 24'hFFFFFF, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd0, 24'h000000);
		plan_row(wrs_pkg::ACT_SELECT, 16'h0000, 24'h000000, 1'b1, 8'd0, wrs_pkg::STS_EMPTY,
			9'd0, 24'h000000);
		plan_row(wrs_pkg::ACT_ADD,    16'hAAAA, 24'h555555, 1'b1, 8'd0, wrs_pkg::STS_OK,
			9'd1, 24'h00AAAA);
		plan_row(wrs_pkg::ACT_SELECT, 16'h5555, 24'h005555, 1'b0, '0,   '0,
			'0,   '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_request(plan[i].req, plan[i].typed, plan[i].want);
		run_random();
		req_valid <= 1'b0;

		// drain, then leave room for a stray late result
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (MAX_ENTRIES + 20) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: random stalls, one long hold-off so the block backs up
	// into its input, and a field-by-field check against the oldest outcome.
	initial begin : result_side
		int            stall;
		wrs_pkg::rsp_t want;
		wrs_pkg::rsp_t got;
		rsp_ready     <= 1'b0;
		results_taken = 0;
		drain_burst   = 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if ($urandom_range(0, 63) == 0)
				drain_burst = !drain_burst;
			stall = drain_burst ? 0 : $urandom_range(0, 10);
			if (results_taken == HOLD_AFTER)
				stall = HOLD_CYCLES;
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			got = rsp_data;
			results_taken++;
			if (pending_outcomes.size() == 0) begin
				$error("result with no request outstanding: index %0d status %0d count %0d total %h",
					got.index, got.status, got.count, got.total);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				if (got.index !== want.index) begin
					$error("index: expected %0d, got %0d", want.index, got.index);
					mismatches++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatches++;
				end
				if (got.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, got.count);
					mismatches++;
				end
				if (got.total !== want.total) begin
					$error("total: expected %h, got %h", want.total, got.total);
					mismatches++;
				end
			end
		end
	end

endmodule

### filelist.f
design/wrs_pkg.sv
design/wrs_ctrl.sv
design/wrs_dpath.sv
design/weighted_roulette_selector.sv
bench/testbench.sv
